@@ hw/rtl/cvr_pkg.sv @@
// shared types, widths and constants of the collinear vertex reducer
package cvr_pkg;

  localparam int unsigned CoordBits  = 24;
  localparam int unsigned SumBits    = 40;
  localparam int unsigned CountBits  = 17;
  localparam int unsigned TolBits    = 51;
  localparam int unsigned MaxPoints  = 65536;
  localparam int unsigned QueueDepth = 4;

  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned CrossBits = ProdBits + 1;

  localparam logic [CountBits-1:0] CountMax = CountBits'(MaxPoints);
  localparam logic [CoordBits-1:0] CoordMax = {1'b0, {(CoordBits-1){1'b1}}};
  localparam logic [CoordBits-1:0] CoordMin = {1'b1, {(CoordBits-1){1'b0}}};

  typedef enum logic {
    CFG_TOLERANCE      = 1'b0,
    CFG_REMOVE_ALIGNED = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DECIDE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINAL
  } back_state_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] pt_x;
    logic signed [CoordBits-1:0] pt_y;
    logic                        pt_last;
  } point_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] vert_x;
    logic signed [CoordBits-1:0] vert_y;
    logic                        final_vertex;
    logic signed [CoordBits-1:0] box_min_x;
    logic signed [CoordBits-1:0] box_min_y;
    logic signed [CoordBits-1:0] box_max_x;
    logic signed [CoordBits-1:0] box_max_y;
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic        [CountBits-1:0] kept_total;
    logic                        shape_error;
  } vertex_t;

endpackage

@@ hw/rtl/cvr_queue.sv @@
// input word queue between the accepting front and the processing back end
module cvr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  cvr_pkg::point_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output cvr_pkg::point_t pop_data_o
);

  localparam int unsigned PtrBits = $clog2(cvr_pkg::QueueDepth);
  localparam int unsigned CntBits = $clog2(cvr_pkg::QueueDepth + 1);

  cvr_pkg::point_t    mem_q [cvr_pkg::QueueDepth];
  logic [PtrBits-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0] count_q, count_d;
  logic               push, pop;

  assign push_ready_o = (count_q != CntBits'(cvr_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrBits'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrBits'(1) : rd_ptr_q;
    unique case ({push, pop})
      2'b10:   count_d = count_q + CntBits'(1);
      2'b01:   count_d = count_q - CntBits'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ hw/rtl/cvr_div.sv @@
// restoring divider for the centroid, one quotient bit per cycle, saturating result
module cvr_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic signed [cvr_pkg::SumBits-1:0]   dividend_i,
  input  logic        [cvr_pkg::CountBits-1:0] divisor_i,
  output logic                                 busy_o,
  output logic signed [cvr_pkg::CoordBits-1:0] quot_o
);

  localparam int unsigned SumBits   = cvr_pkg::SumBits;
  localparam int unsigned CountBits = cvr_pkg::CountBits;
  localparam int unsigned CoordBits = cvr_pkg::CoordBits;
  localparam int unsigned StepBits  = $clog2(SumBits);
  localparam logic [StepBits-1:0] LastStep = StepBits'(SumBits - 1);
  localparam logic [SumBits-1:0]  NegLimit = SumBits'(1) << (CoordBits - 1);

  logic                 busy_q;
  logic [StepBits-1:0]  cnt_q;
  logic                 neg_q;
  logic [CountBits-1:0] div_q;
  logic [CountBits-1:0] rem_q, rem_d;
  logic [SumBits-1:0]   quo_q, quo_d;
  logic [SumBits-1:0]   mag_in;
  logic [CountBits:0]   shifted, trial;
  logic                 fits;

  assign mag_in  = dividend_i[SumBits-1] ? (~dividend_i + 1'b1) : dividend_i;
  assign shifted = {rem_q, quo_q[SumBits-1]};
  assign trial   = shifted - {1'b0, div_q};
  assign fits    = !trial[CountBits];

  always_comb begin
    rem_d = fits ? trial[CountBits-1:0] : shifted[CountBits-1:0];
    quo_d = {quo_q[SumBits-2:0], fits};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + StepBits'(1);
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= mag_in;
      rem_q <= '0;
      neg_q <= dividend_i[SumBits-1];
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  // truncation toward zero, clamp to the coordinate range
  always_comb begin
    if (!neg_q) begin
      quot_o = (|quo_q[SumBits-1:CoordBits-1]) ? cvr_pkg::CoordMax : quo_q[CoordBits-1:0];
    end else begin
      quot_o = (quo_q > NegLimit) ? cvr_pkg::CoordMin : (~quo_q[CoordBits-1:0] + 1'b1);
    end
  end

  assign busy_o = busy_q;

  a_full_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> $past(cnt_q) == LastStep)
    else $error("divider finished early");

endmodule

@@ hw/rtl/cvr_back.sv @@
// back end: collinear test, vertex state, running summary and result register
module cvr_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 pt_valid_i,
  output logic                                 pt_ready_o,
  input  cvr_pkg::point_t                      pt_i,
  input  logic        [cvr_pkg::TolBits-1:0]   tolerance_i,
  input  logic                                 remove_aligned_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output cvr_pkg::vertex_t                     out_o
);

  localparam int unsigned CoordBits = cvr_pkg::CoordBits;
  localparam int unsigned SumBits   = cvr_pkg::SumBits;
  localparam int unsigned CountBits = cvr_pkg::CountBits;
  localparam int unsigned DiffBits  = cvr_pkg::DiffBits;
  localparam int unsigned ProdBits  = cvr_pkg::ProdBits;
  localparam int unsigned CrossBits = cvr_pkg::CrossBits;

  cvr_pkg::back_state_e state_q, state_d;

  logic signed [CoordBits-1:0] cur_x_q, cur_y_q;
  logic                        cur_last_q;
  logic signed [CoordBits-1:0] older_x_q, older_y_q;
  logic signed [CoordBits-1:0] pend_x_q, pend_y_q;
  logic signed [CoordBits-1:0] start_x_q, start_y_q;
  logic signed [CoordBits-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [SumBits-1:0]   sum_x_q, sum_y_q;
  logic        [CountBits-1:0] seen_q, kept_q;

  logic signed [DiffBits-1:0]  da_x_d, da_y_d, db_x_d, db_y_d;
  logic signed [DiffBits-1:0]  da_x_q, da_y_q, db_x_q, db_y_q;
  logic signed [ProdBits-1:0]  prod_a_q, prod_b_q;
  logic signed [CrossBits-1:0] cross_prod;
  logic        [CrossBits-1:0] mag;
  logic                        collinear;

  logic             out_valid_q;
  cvr_pkg::vertex_t out_q, out_d;
  logic             out_free;

  logic pop, first, decide_fire, emit_plain, emit_final, div_start;
  logic div_busy_x, div_busy_y;
  logic signed [CoordBits-1:0] center_x, center_y;

  assign out_free = !out_valid_q || out_ready_i;
  assign pop      = pt_valid_i && pt_ready_o;
  assign first    = (seen_q == '0);

  // edge vectors from the older vertex, taken while the word leaves the queue
  assign da_x_d = {pt_i.pt_x[CoordBits-1], pt_i.pt_x} - {older_x_q[CoordBits-1], older_x_q};
  assign da_y_d = {pt_i.pt_y[CoordBits-1], pt_i.pt_y} - {older_y_q[CoordBits-1], older_y_q};
  assign db_x_d = {pend_x_q[CoordBits-1], pend_x_q} - {older_x_q[CoordBits-1], older_x_q};
  assign db_y_d = {pend_y_q[CoordBits-1], pend_y_q} - {older_y_q[CoordBits-1], older_y_q};

  assign cross_prod = {prod_a_q[ProdBits-1], prod_a_q} - {prod_b_q[ProdBits-1], prod_b_q};
  assign mag        = cross_prod[CrossBits-1] ? (~cross_prod + 1'b1) : cross_prod;
  assign collinear  = remove_aligned_i && (kept_q >= CountBits'(2)) && (mag <= tolerance_i);

  always_comb begin
    state_d     = state_q;
    pt_ready_o  = 1'b0;
    decide_fire = 1'b0;
    emit_plain  = 1'b0;
    emit_final  = 1'b0;
    div_start   = 1'b0;
    unique case (state_q)
      cvr_pkg::ST_IDLE: begin
        pt_ready_o = 1'b1;
        if (pt_valid_i) begin
          state_d = cvr_pkg::ST_MUL;
        end
      end
      cvr_pkg::ST_MUL: begin
        state_d = cvr_pkg::ST_DECIDE;
      end
      cvr_pkg::ST_DECIDE: begin
        if (collinear || kept_q == '0 || out_free) begin
          decide_fire = 1'b1;
          emit_plain  = !collinear && (kept_q != '0);
          state_d     = cur_last_q ? cvr_pkg::ST_DIV_GO : cvr_pkg::ST_IDLE;
        end
      end
      cvr_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_d   = cvr_pkg::ST_DIV_WAIT;
      end
      cvr_pkg::ST_DIV_WAIT: begin
        if (!(div_busy_x || div_busy_y)) begin
          state_d = cvr_pkg::ST_FINAL;
        end
      end
      cvr_pkg::ST_FINAL: begin
        if (out_free) begin
          emit_final = 1'b1;
          state_d    = cvr_pkg::ST_IDLE;
        end
      end
      default: state_d = cvr_pkg::ST_IDLE;
    endcase
  end

  // plain words carry only the vertex, the final word adds the summary
  always_comb begin
    out_d        = '0;
    out_d.vert_x = pend_x_q;
    out_d.vert_y = pend_y_q;
    if (emit_final) begin
      out_d.final_vertex = 1'b1;
      out_d.box_min_x    = min_x_q;
      out_d.box_min_y    = min_y_q;
      out_d.box_max_x    = max_x_q;
      out_d.box_max_y    = max_y_q;
      out_d.center_x     = center_x;
      out_d.center_y     = center_y;
      out_d.kept_total   = kept_q;
      out_d.shape_error  = (kept_q < CountBits'(3)) || (start_x_q != pend_x_q)
                           || (start_y_q != pend_y_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cvr_pkg::ST_IDLE;
      seen_q      <= '0;
      kept_q      <= '0;
      sum_x_q     <= '0;
      sum_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop) begin
        sum_x_q <= sum_x_q + {{(SumBits-CoordBits){pt_i.pt_x[CoordBits-1]}}, pt_i.pt_x};
        sum_y_q <= sum_y_q + {{(SumBits-CoordBits){pt_i.pt_y[CoordBits-1]}}, pt_i.pt_y};
        if (seen_q != cvr_pkg::CountMax) begin
          seen_q <= seen_q + CountBits'(1);
        end
      end
      if (decide_fire && !collinear && kept_q != cvr_pkg::CountMax) begin
        kept_q <= kept_q + CountBits'(1);
      end
      if (emit_final) begin
        seen_q  <= '0;
        kept_q  <= '0;
        sum_x_q <= '0;
        sum_y_q <= '0;
      end
      if (emit_plain || emit_final) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_x_q    <= pt_i.pt_x;
      cur_y_q    <= pt_i.pt_y;
      cur_last_q <= pt_i.pt_last;
      da_x_q     <= da_x_d;
      da_y_q     <= da_y_d;
      db_x_q     <= db_x_d;
      db_y_q     <= db_y_d;
      if (first) begin
        start_x_q <= pt_i.pt_x;
        start_y_q <= pt_i.pt_y;
      end
      if (first || pt_i.pt_x < min_x_q) min_x_q <= pt_i.pt_x;
      if (first || pt_i.pt_y < min_y_q) min_y_q <= pt_i.pt_y;
      if (first || pt_i.pt_x > max_x_q) max_x_q <= pt_i.pt_x;
      if (first || pt_i.pt_y > max_y_q) max_y_q <= pt_i.pt_y;
    end
    if (state_q == cvr_pkg::ST_MUL) begin
      prod_a_q <= ProdBits'(da_x_q) * ProdBits'(db_y_q);
      prod_b_q <= ProdBits'(da_y_q) * ProdBits'(db_x_q);
    end
    if (decide_fire) begin
      if (!collinear) begin
        older_x_q <= pend_x_q;
        older_y_q <= pend_y_q;
      end
      pend_x_q <= cur_x_q;
      pend_y_q <= cur_y_q;
    end
    if (emit_plain || emit_final) begin
      out_q <= out_d;
    end
  end

  cvr_div u_div_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_x_q),
    .divisor_i  (seen_q),
    .busy_o     (div_busy_x),
    .quot_o     (center_x)
  );

  cvr_div u_div_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_y_q),
    .divisor_i  (seen_q),
    .busy_o     (div_busy_y),
    .quot_o     (center_y)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_final |=> seen_q == '0 && kept_q == '0 && sum_x_q == '0)
    else $error("polygon state not cleared after final word");

  a_final_has_vertex: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.final_vertex |-> out_q.kept_total != '0)
    else $error("final word with no kept vertex");

  a_plain_no_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.final_vertex |-> out_q.kept_total == '0 && !out_q.shape_error)
    else $error("summary fields set on a plain vertex word");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cvr_pkg::ST_DIV_WAIT |-> div_busy_x == div_busy_y)
    else $error("centroid dividers out of step");

endmodule

@@ hw/rtl/collinear_vertex_reducer.sv @@
// an accepted word is popped, multiplied and tested; a non-collinear test emits the previous pending vertex
// the back end sequencer takes a new word only after the last one's fetch, multiply and test steps
// closing vertex: divider start, 40 quotient steps, handover and final word follow the test
// the 4-entry input queue keeps accepting, until full, while the back end computes or the output stalls
// reset (async, active low): queue empty, polygon state cleared, tolerance 0, removal enabled
module collinear_vertex_reducer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  cvr_pkg::point_t                    in_data_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output cvr_pkg::vertex_t                   out_data_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  cvr_pkg::cfg_idx_e                  cfg_index_i,
  input  logic        [cvr_pkg::TolBits-1:0] cfg_data_i
);

  logic [cvr_pkg::TolBits-1:0] tolerance_q;
  logic                        remove_aligned_q;
  logic                        q_valid, q_ready;
  cvr_pkg::point_t             q_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerance_q      <= '0;
      remove_aligned_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        cvr_pkg::CFG_TOLERANCE:      tolerance_q      <= cfg_data_i;
        cvr_pkg::CFG_REMOVE_ALIGNED: remove_aligned_q <= cfg_data_i[0];
        default:                     tolerance_q      <= tolerance_q;
      endcase
    end
  end

  cvr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (in_data_i),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_data)
  );

  cvr_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pt_valid_i       (q_valid),
    .pt_ready_o       (q_ready),
    .pt_i             (q_data),
    .tolerance_i      (tolerance_q),
    .remove_aligned_i (remove_aligned_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .out_o            (out_data_o)
  );

endmodule

@@ test/tb.sv @@
// self-checking testbench for the collinear vertex reducer
`timescale 1ns / 100ps

module tb;

  localparam int XMax        = 8388607;
  localparam int XMin        = -8388608;
  localparam int LongHold    = 400;
  localparam int DrainCycles = 100;
  localparam int CycleLimit  = 3000000;
  localparam longint CoordHi = (longint'(1) << (cvr_pkg::CoordBits - 1)) - 1;
  localparam longint CoordLo = -CoordHi - 1;

  logic                        clk_i       = 1'b0;
  logic                        rst_ni      = 1'b0;
  logic                        in_valid_i  = 1'b0;
  logic                        in_ready_o;
  cvr_pkg::point_t             in_data_i   = '0;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  cvr_pkg::vertex_t            out_data_o;
  logic                        cfg_valid_i = 1'b0;
  logic                        cfg_ready_o;
  cvr_pkg::cfg_idx_e           cfg_index_i = cvr_pkg::CFG_TOLERANCE;
  logic [cvr_pkg::TolBits-1:0] cfg_data_i  = '0;

  collinear_vertex_reducer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // stimulus and expectation stores
  cvr_pkg::point_t  pts_q[$];
  cvr_pkg::vertex_t exp_vertices[$];
  int      pts_total   = 0;
  int      words_seen  = 0;
  int      mismatches  = 0;
  int      cycles      = 0;
  int      tx_idle_pct = 0;
  int      rx_idle_pct = 0;
  bit      in_took     = 1'b0;
  bit      rx_hold     = 1'b0;
  event    rx_hold_ev;

  // predictor state: registers and the polygon in progress
  logic [cvr_pkg::TolBits-1:0]        cfg_tol  = '0;
  bit                                 cfg_drop = 1'b1;
  longint                             anchor_x, anchor_y, cand_x, cand_y, first_x, first_y;
  longint                             lo_x, lo_y, hi_x, hi_y;
  logic signed [cvr_pkg::SumBits-1:0] acc_x, acc_y;
  int unsigned                        n_in, n_kept;

  function automatic void clear_polygon();
    anchor_x = 0; anchor_y = 0; cand_x = 0; cand_y = 0; first_x = 0; first_y = 0;
    lo_x = 0; lo_y = 0; hi_x = 0; hi_y = 0;
    acc_x = '0; acc_y = '0;
    n_in = 0; n_kept = 0;
  endfunction

  function automatic logic [cvr_pkg::CoordBits-1:0] mean_of(
      logic signed [cvr_pkg::SumBits-1:0] total);
    longint q;
    q = longint'(total) / longint'(n_in);
    if (q > CoordHi) q = CoordHi;
    if (q < CoordLo) q = CoordLo;
    return cvr_pkg::CoordBits'(q);
  endfunction

  function automatic cvr_pkg::vertex_t vertex_word(bit closing);
    cvr_pkg::vertex_t v;
    v = '0;
    v.vert_x = cvr_pkg::CoordBits'(cand_x);
    v.vert_y = cvr_pkg::CoordBits'(cand_y);
    if (closing) begin
      v.final_vertex = 1'b1;
      v.box_min_x    = cvr_pkg::CoordBits'(lo_x);
      v.box_min_y    = cvr_pkg::CoordBits'(lo_y);
      v.box_max_x    = cvr_pkg::CoordBits'(hi_x);
      v.box_max_y    = cvr_pkg::CoordBits'(hi_y);
      v.center_x     = mean_of(acc_x);
      v.center_y     = mean_of(acc_y);
      v.kept_total   = cvr_pkg::CountBits'(n_kept);
      v.shape_error  = (n_kept < 3) || (first_x != cand_x) || (first_y != cand_y);
    end
    return v;
  endfunction

  function automatic void reduce_point(cvr_pkg::point_t p);
    longint x, y, cr_val, mag;
    bit     merge;
    x = longint'($signed(p.pt_x));
    y = longint'($signed(p.pt_y));
    if (n_in == 0) begin
      lo_x = x; hi_x = x; lo_y = y; hi_y = y;
      first_x = x; first_y = y;
    end else begin
      if (x < lo_x) lo_x = x;
      if (y < lo_y) lo_y = y;
      if (x > hi_x) hi_x = x;
      if (y > hi_y) hi_y = y;
    end
    acc_x = acc_x + cvr_pkg::SumBits'(x);
    acc_y = acc_y + cvr_pkg::SumBits'(y);
    if (n_in < cvr_pkg::MaxPoints) n_in++;
    merge = 1'b0;
    if (cfg_drop && n_kept >= 2) begin
      cr_val = (x - anchor_x) * (cand_y - anchor_y) - (y - anchor_y) * (cand_x - anchor_x);
      mag    = (cr_val < 0) ? -cr_val : cr_val;
      merge  = mag <= longint'(cfg_tol);
    end
    if (merge) begin
      cand_x = x;
      cand_y = y;
    end else begin
      if (n_kept >= 1) exp_vertices.push_back(vertex_word(1'b0));
      anchor_x = cand_x;
      anchor_y = cand_y;
      cand_x   = x;
      cand_y   = y;
      if (n_kept < cvr_pkg::MaxPoints) n_kept++;
    end
    if (p.pt_last) begin
      exp_vertices.push_back(vertex_word(1'b1));
      clear_polygon();
    end
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    $display("mismatch on word %0d: %s got %h expected %h", words_seen, what, got, want);
  endtask

  task automatic compare_vertex(cvr_pkg::vertex_t got, cvr_pkg::vertex_t want);
    if (got.vert_x !== want.vert_x) report_mismatch("vert_x", got.vert_x, want.vert_x);
    if (got.vert_y !== want.vert_y) report_mismatch("vert_y", got.vert_y, want.vert_y);
    if (got.final_vertex !== want.final_vertex)
      report_mismatch("final_vertex", got.final_vertex, want.final_vertex);
    if (got.box_min_x !== want.box_min_x)
      report_mismatch("box_min_x", got.box_min_x, want.box_min_x);
    if (got.box_min_y !== want.box_min_y)
      report_mismatch("box_min_y", got.box_min_y, want.box_min_y);
    if (got.box_max_x !== want.box_max_x)
      report_mismatch("box_max_x", got.box_max_x, want.box_max_x);
    if (got.box_max_y !== want.box_max_y)
      report_mismatch("box_max_y", got.box_max_y, want.box_max_y);
    if (got.center_x !== want.center_x)
      report_mismatch("center_x", got.center_x, want.center_x);
    if (got.center_y !== want.center_y)
      report_mismatch("center_y", got.center_y, want.center_y);
    if (got.kept_total !== want.kept_total)
      report_mismatch("kept_total", got.kept_total, want.kept_total);
    if (got.shape_error !== want.shape_error)
      report_mismatch("shape_error", got.shape_error, want.shape_error);
  endtask

  // monitor: register writes, accepted points and returned words, all at the rising edge
  always @(posedge clk_i) begin
    in_took = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          cvr_pkg::CFG_TOLERANCE:      cfg_tol  = cfg_data_i;
          cvr_pkg::CFG_REMOVE_ALIGNED: cfg_drop = cfg_data_i[0];
          default: ;
        endcase
      end
      if (in_took) reduce_point(in_data_i);
      if (out_valid_o && out_ready_i) begin
        words_seen++;
        if (exp_vertices.size() == 0)
          report_mismatch("word with nothing expected", out_data_o.vert_x, '0);
        else
          compare_vertex(out_data_o, exp_vertices.pop_front());
      end
    end
  end

  // driver: both handshake sides change at the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || in_took) begin
        if (pts_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_data_i  <= pts_q.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      out_ready_i <= !rx_hold && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // long receiver stall so the input queue fills and backs up
  always begin
    @(rx_hold_ev);
    rx_hold = 1'b1;
    repeat (LongHold) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int rand_in(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic int clamp_coord(int v);
    if (v > XMax) return XMax;
    if (v < XMin) return XMin;
    return v;
  endfunction

  function automatic int pick_reach();
    int r;
    r = $urandom_range(9);
    if (r < 4) return 300;
    if (r < 7) return 65535;
    return XMax;
  endfunction

  task automatic add_point(int x, int y, bit last);
    cvr_pkg::point_t p;
    p.pt_x    = cvr_pkg::CoordBits'(x);
    p.pt_y    = cvr_pkg::CoordBits'(y);
    p.pt_last = last;
    pts_q.push_back(p);
    pts_total++;
  endtask

  // corners joined by straight runs of points; multiples of 12 keep the runs exact
  task automatic add_closed_polygon(bit broken);
    int cx[6], cy[6];
    int corners, reach, i, j, k, m, px, py;
    bit exact;
    corners = $urandom_range(2, 6);
    reach   = pick_reach();
    exact   = $urandom_range(1);
    for (i = 0; i < corners; i++) begin
      cx[i] = rand_in(-reach - 1, reach);
      cy[i] = rand_in(-reach - 1, reach);
      if (exact) begin
        cx[i] = (cx[i] / 12) * 12;
        cy[i] = (cy[i] / 12) * 12;
      end
    end
    for (i = 0; i < corners; i++) begin
      j = (i + 1) % corners;
      m = $urandom_range(1, 4);
      for (k = 0; k < m; k++) begin
        px = cx[i] + (cx[j] - cx[i]) * k / m;
        py = cy[i] + (cy[j] - cy[i]) * k / m;
        if (i + k > 0 && $urandom_range(7) == 0) begin
          px = clamp_coord(px + rand_in(-2, 2));
          py = clamp_coord(py + rand_in(-2, 2));
        end
        add_point(px, py, 1'b0);
        if ($urandom_range(15) == 0) add_point(px, py, 1'b0);
      end
    end
    add_point(broken ? (cx[0] ^ 1) : cx[0], cy[0], 1'b1);
  endtask

  task automatic add_noise();
    int n, i;
    n = $urandom_range(1, 8);
    for (i = 0; i < n; i++)
      add_point(rand_in(XMin, XMax), rand_in(XMin, XMax), i == n - 1);
  endtask

  task automatic add_random_items(int goal);
    int mark, r;
    mark = pts_total;
    while (pts_total - mark < goal) begin
      r = $urandom_range(9);
      if (r < 8) add_closed_polygon(1'b0);
      else if (r == 8) add_closed_polygon(1'b1);
      else add_noise();
    end
  endtask

  // wait until every point is taken and every word is back, then let the block go quiet
  task automatic settle();
    while (pts_q.size() != 0 || in_valid_i || exp_vertices.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cvr_pkg::cfg_idx_e idx, logic [cvr_pkg::TolBits-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_regs(logic [cvr_pkg::TolBits-1:0] tol, bit drop);
    logic [cvr_pkg::TolBits-1:0] flag_word;
    settle();
    write_reg(cvr_pkg::CFG_TOLERANCE, tol);
    // upper bits of the removal word are don't-care
    flag_word    = cvr_pkg::TolBits'({$urandom(), $urandom()});
    flag_word[0] = drop;
    write_reg(cvr_pkg::CFG_REMOVE_ALIGNED, flag_word);
  endtask

  task automatic run_phase(logic [cvr_pkg::TolBits-1:0] tol, bit drop, int tx_pct, int rx_pct);
    set_regs(tol, drop);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    add_random_items(250);
  endtask

  initial begin
    tx_idle_pct = 19;
    rx_idle_pct = 82;
    clear_polygon();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part with the reset register values
    add_point(XMax, XMin, 1'b1);                  // lone point, final word only
    add_point(XMin, XMax, 1'b0);
    add_point(XMax, XMin, 1'b1);                  // two points, open
    add_point(0, 0, 1'b0);                        // square with a midpoint on one edge
    add_point(4096, 0, 1'b0);
    add_point(8192, 0, 1'b0);
    add_point(8192, 8192, 1'b0);
    add_point(0, 8192, 1'b0);
    add_point(0, 0, 1'b1);
    add_point(XMin, XMin, 1'b0);                  // largest cross product
    add_point(XMax, XMin, 1'b0);
    add_point(XMax, XMax, 1'b0);
    add_point(XMin, XMin, 1'b1);
    add_point(1, 1, 1'b0);                        // not closed
    add_point(5, 2, 1'b0);
    add_point(3, 9, 1'b1);
    add_point(0, 0, 1'b0);                        // all on one line
    add_point(1, 1, 1'b0);
    add_point(2, 2, 1'b0);
    add_point(0, 0, 1'b1);

    run_phase('0, 1'b1, 19, 82);
    -> rx_hold_ev;
    run_phase(cvr_pkg::TolBits'($urandom_range(4096)), 1'b1, 19, 82);
    run_phase({cvr_pkg::TolBits{1'b1}}, 1'b1, 82, 19);
    run_phase(cvr_pkg::TolBits'({$urandom(), $urandom()}), 1'b0, 82, 19);
    run_phase(cvr_pkg::TolBits'($urandom_range(65536)), 1'b1, 0, 0);

    // removal off with zero tolerance
    run_phase('0, 1'b0, 0, 0);

    run_phase(cvr_pkg::TolBits'(longint'(1) << 40), 1'b1, 0, 0);

    settle();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/cvr_pkg.sv
hw/rtl/cvr_queue.sv
hw/rtl/cvr_div.sv
hw/rtl/cvr_back.sv
hw/rtl/collinear_vertex_reducer.sv
test/tb.sv
